[hw/rtl/ascii_integer_parser_assert.svh]
// Assertion macros used by the checker file of the ASCII integer parser.
// No dependencies; include by bare file name.
`ifndef ASCII_INTEGER_PARSER_ASSERT_SVH
`define ASCII_INTEGER_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AIP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed in ascii_integer_parser");

// Next-cycle implication, disabled while reset is asserted.
`define AIP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed in ascii_integer_parser");

`endif

[hw/rtl/aip_pkg.sv]
// Shared types, codes and character helpers of the ASCII integer parser.
// No dependencies; used by the parse core, the top level and the checker.
package aip_pkg;

    typedef enum logic [1:0] {
        AIP_OK      = 2'd0,
        AIP_INVALID = 2'd1,
        AIP_RANGE   = 2'd2
    } aip_status_t;

    typedef enum logic [1:0] {
        REG_RADIX  = 2'd0,
        REG_SIGNED = 2'd1,
        REG_WIDTH  = 2'd2
    } aip_reg_t;

    localparam logic [1:0] WSEL_8  = 2'd0;
    localparam logic [1:0] WSEL_16 = 2'd1;
    localparam logic [1:0] WSEL_32 = 2'd2;
    localparam logic [1:0] WSEL_64 = 2'd3;

    localparam logic [5:0] RADIX_AUTO = 6'd0;
    localparam logic [5:0] RADIX_BIN  = 6'd2;
    localparam logic [5:0] RADIX_OCT  = 6'd8;
    localparam logic [5:0] RADIX_DEC  = 6'd10;
    localparam logic [5:0] RADIX_HEX  = 6'd16;
    localparam logic [5:0] RADIX_MAX  = 6'd36;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    // Digit value of a character that is no digit in any radix.
    localparam logic [6:0] DIGIT_NONE = 7'd64;
    localparam logic [6:0] DIGIT_TEN  = 7'd10;

    typedef struct packed {
        logic [5:0] radix;
        logic       signed_mode;
        logic [1:0] width_sel;
    } aip_cfg_t;

    typedef struct packed {
        logic       valid;
        logic       last;
        logic [7:0] char_byte;
    } aip_beat_t;

    function automatic logic [6:0] digit_of(input logic [7:0] c);
        logic [6:0] d;
        d = DIGIT_NONE;
        if (c inside {[CH_0:CH_9]}) begin
            d = 7'(c - CH_0);
        end else if (c inside {[CH_UA:CH_UZ]}) begin
            d = 7'(c - CH_UA) + DIGIT_TEN;
        end else if (c inside {[CH_LA:CH_LZ]}) begin
            d = 7'(c - CH_LA) + DIGIT_TEN;
        end
        return d;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
    endfunction

endpackage

[hw/rtl/ascii_integer_parser.sv]
// Top level of the ASCII integer parser: stream ports, configuration
// registers, input and output beat registers. Depends on aip_pkg, aip_parse_core.
//
// Converts a character stream into integers, one string per result. Each beat
// on s_ carries one character; the beat with s_tlast closes the string and
// produces exactly one result beat on m_. A character is accepted every cycle
// with no gaps between strings, unless a closing beat waits for room in the
// finishing stage; the result passes the input, finishing and output registers
// and stays in the last while m_tready holds it back. The clock rate is set by the
// per-character step: a VALUE_BITS by 6 bit multiply-add and its compare
// against the width limit. Configuration writes are accepted at any time and
// take effect from the next character processed; write them only between
// strings.
module ascii_integer_parser #(
    parameter int unsigned VALUE_BITS = 64,
    parameter int unsigned COUNT_BITS = 16,
    localparam int unsigned M_TDATA_BITS = ((VALUE_BITS + 2 + COUNT_BITS + 7) / 8) * 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration write channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [5:0]               cfg_data,
    // character stream
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,   // char_byte
    input  logic                     s_tlast,   // last_char
    // result stream
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [M_TDATA_BITS-1:0]  m_tdata    // value_bits, status, end_count, zero pad
);
    import aip_pkg::*;

    logic [5:0]  radix_reg;
    logic        signed_reg;
    logic [1:0]  wsel_reg;

    logic        in_valid_reg;
    logic        in_last_reg;
    logic [7:0]  in_char_reg;

    logic                    m_tvalid_reg;
    logic [M_TDATA_BITS-1:0] m_tdata_reg;

    aip_cfg_t              cfg;
    aip_beat_t             beat;
    logic                  advance;
    logic                  out_free;
    logic                  fin_valid;
    logic                  fin_free;
    logic [VALUE_BITS-1:0] res_value;
    logic [COUNT_BITS-1:0] res_count;
    aip_status_t           res_status;

    assign cfg_ready = 1'b1;

    assign cfg.radix       = radix_reg;
    assign cfg.signed_mode = signed_reg;
    assign cfg.width_sel   = wsel_reg;

    // A closing beat waits until the finishing stage has room.
    assign advance  = in_valid_reg && (!in_last_reg || fin_free);
    assign s_tready = !in_valid_reg || advance;
    assign out_free = !m_tvalid_reg || m_tready;

    assign beat.valid     = advance;
    assign beat.last      = in_last_reg;
    assign beat.char_byte = in_char_reg;

    aip_parse_core #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .beat       (beat),
        .fin_take   (out_free),
        .fin_valid  (fin_valid),
        .fin_free   (fin_free),
        .res_value  (res_value),
        .res_count  (res_count),
        .res_status (res_status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_AUTO;
            signed_reg <= 1'b0;
            wsel_reg <= WSEL_64;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_RADIX:  radix_reg  <= cfg_data;
                REG_SIGNED: signed_reg <= cfg_data[0];
                REG_WIDTH:  wsel_reg   <= cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (fin_valid && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (fin_valid && out_free) begin
            m_tdata_reg <= M_TDATA_BITS'({res_count, res_status, res_value});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[hw/rtl/aip_parse_core.sv]
// Parse state of the ASCII integer parser: one character step per cycle in which a beat is
// valid, and a finishing stage that closes a string. Depends on aip_pkg.
module aip_parse_core #(
    parameter int unsigned VALUE_BITS = 64,
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  aip_pkg::aip_cfg_t       cfg,
    input  aip_pkg::aip_beat_t      beat,
    input  logic                    fin_take,
    output logic                    fin_valid,
    output logic                    fin_free,
    output logic [VALUE_BITS-1:0]   res_value,
    output logic [COUNT_BITS-1:0]   res_count,
    output aip_pkg::aip_status_t    res_status
);
    import aip_pkg::*;

    localparam int unsigned PROD_BITS = VALUE_BITS + 7;

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_SIGN,
        PH_ZAUTO,
        PH_ZFIX,
        PH_PREFIX,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    typedef struct packed {
        phase_t                 phase;
        logic [VALUE_BITS-1:0]  acc;
        logic                   neg;
        logic [5:0]             radix;
        logic [COUNT_BITS-1:0]  cnt;
        logic [COUNT_BITS-1:0]  zpc;
        aip_status_t            status;
    } pstate_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0]  acc;
        aip_status_t            status;
    } done_t;

    localparam pstate_t ST_CLEAR = '{
        phase:  PH_SKIP,
        acc:    '0,
        neg:    1'b0,
        radix:  '0,
        cnt:    '0,
        zpc:    '0,
        status: AIP_OK
    };

    pstate_t st_reg, st_next;
    pstate_t fin_reg, fin_next;
    logic    fin_valid_reg, fin_valid_next;

    logic [VALUE_BITS-1:0] mask;

    function automatic logic [VALUE_BITS-1:0] limit_of(
        input logic [VALUE_BITS-1:0] m,
        input logic                  neg,
        input logic                  sgn
    );
        logic [VALUE_BITS-1:0] half;
        half = m >> 1;
        if (!sgn) begin
            return m;
        end
        return neg ? half + 1'b1 : half;
    endfunction

    // Clamp or sign the magnitude once the digit run has ended.
    function automatic done_t finish_value(
        input logic [VALUE_BITS-1:0] acc,
        input aip_status_t           status,
        input logic                  neg,
        input logic [VALUE_BITS-1:0] m,
        input logic                  sgn
    );
        done_t                 r;
        logic [VALUE_BITS-1:0] lim;
        lim = limit_of(m, neg, sgn);
        if (status == AIP_RANGE || acc > lim) begin
            r.acc    = lim;
            r.status = AIP_RANGE;
        end else begin
            r.acc    = neg ? (({VALUE_BITS{1'b0}} - acc) & m) : (acc & m);
            r.status = status;
        end
        return r;
    endfunction

    always_comb begin
        case (cfg.width_sel)
            WSEL_8:  mask = VALUE_BITS'({8{1'b1}});
            WSEL_16: mask = VALUE_BITS'({16{1'b1}});
            WSEL_32: mask = VALUE_BITS'({32{1'b1}});
            default: mask = VALUE_BITS'({64{1'b1}});
        endcase
    end

    // One character step.
    always_comb begin
        pstate_t               nx;
        done_t                 fd;
        logic [7:0]            ch;
        logic [6:0]            dig;
        logic                  radix_ok;
        logic [COUNT_BITS-1:0] cnt_inc;
        logic                  do_digit;
        logic                  do_fin;
        logic                  make_invalid;
        logic [5:0]            base;
        logic [VALUE_BITS-1:0] acc_in;
        logic [VALUE_BITS-1:0] fin_acc_in;
        logic [PROD_BITS-1:0]  prod;
        logic [VALUE_BITS-1:0] lim;

        nx           = st_reg;
        ch           = beat.char_byte;
        dig          = digit_of(ch);
        radix_ok     = (cfg.radix >= RADIX_BIN) && (cfg.radix <= RADIX_MAX);
        cnt_inc      = (st_reg.cnt == '1) ? st_reg.cnt : st_reg.cnt + 1'b1;
        do_digit     = 1'b0;
        do_fin       = 1'b0;
        make_invalid = 1'b0;
        base         = st_reg.radix;
        acc_in       = '0;
        fin_acc_in   = '0;
        prod         = '0;
        lim          = '0;

        case (st_reg.phase)
            PH_SKIP, PH_SIGN: begin
                if (st_reg.phase == PH_SKIP && is_blank(ch)) begin
                    nx.cnt = cnt_inc;
                end else if (st_reg.phase == PH_SKIP && (ch == CH_PLUS || ch == CH_MINUS)) begin
                    nx.neg   = (ch == CH_MINUS);
                    nx.cnt   = cnt_inc;
                    nx.phase = PH_SIGN;
                end else if (cfg.radix == RADIX_AUTO) begin
                    if (ch == CH_0) begin
                        nx.cnt   = cnt_inc;
                        nx.phase = PH_ZAUTO;
                    end else if (ch inside {[CH_1:CH_9]}) begin
                        nx.radix = RADIX_DEC;
                        base     = RADIX_DEC;
                        do_digit = 1'b1;
                    end else begin
                        make_invalid = 1'b1;
                    end
                end else if (!radix_ok) begin
                    make_invalid = 1'b1;
                end else if ((cfg.radix == RADIX_HEX || cfg.radix == RADIX_BIN)
                             && ch == CH_0) begin
                    nx.radix = cfg.radix;
                    nx.cnt   = cnt_inc;
                    nx.phase = PH_ZFIX;
                end else if (dig < {1'b0, cfg.radix}) begin
                    nx.radix = cfg.radix;
                    base     = cfg.radix;
                    do_digit = 1'b1;
                end else begin
                    make_invalid = 1'b1;
                end
            end
            PH_ZAUTO: begin
                if (ch inside {CH_LX, CH_UX, CH_LB, CH_UB}) begin
                    nx.zpc   = st_reg.cnt;
                    nx.cnt   = cnt_inc;
                    nx.radix = (ch == CH_LX || ch == CH_UX) ? RADIX_HEX : RADIX_BIN;
                    nx.phase = PH_PREFIX;
                end else begin
                    nx.radix = RADIX_OCT;
                    base     = RADIX_OCT;
                    do_digit = 1'b1;
                end
            end
            PH_ZFIX: begin
                if ((st_reg.radix == RADIX_HEX && (ch == CH_LX || ch == CH_UX)) ||
                    (st_reg.radix == RADIX_BIN && (ch == CH_LB || ch == CH_UB))) begin
                    nx.zpc   = st_reg.cnt;
                    nx.cnt   = cnt_inc;
                    nx.phase = PH_PREFIX;
                end else begin
                    do_digit = 1'b1;
                end
            end
            PH_PREFIX: begin
                if (dig < {1'b0, st_reg.radix}) begin
                    do_digit = 1'b1;
                end else begin
                    // Prefix without a digit: fall back to the lone zero.
                    nx.cnt = st_reg.zpc;
                    do_fin = 1'b1;
                end
            end
            PH_DIGITS: begin
                acc_in   = st_reg.acc;
                do_digit = 1'b1;
            end
            default: begin
            end
        endcase

        if (do_digit) begin
            if (dig >= {1'b0, base}) begin
                do_fin     = 1'b1;
                fin_acc_in = acc_in;
            end else begin
                nx.phase = PH_DIGITS;
                nx.acc   = acc_in;
                nx.cnt   = cnt_inc;
                lim      = limit_of(mask, nx.neg, cfg.signed_mode);
                prod     = PROD_BITS'(acc_in) * PROD_BITS'(base) + PROD_BITS'(dig);
                if (nx.status != AIP_RANGE) begin
                    if (prod > PROD_BITS'(lim)) begin
                        nx.status = AIP_RANGE;
                    end else begin
                        nx.acc = prod[VALUE_BITS-1:0];
                    end
                end
            end
        end

        if (do_fin) begin
            fd        = finish_value(fin_acc_in, nx.status, nx.neg, mask, cfg.signed_mode);
            nx.acc    = fd.acc;
            nx.status = fd.status;
            nx.phase  = PH_DONE;
        end else begin
            fd = '0;
        end

        if (make_invalid) begin
            nx.status = AIP_INVALID;
            nx.acc    = '0;
            nx.cnt    = '0;
            nx.phase  = PH_DONE;
        end

        st_next        = st_reg;
        fin_next       = fin_reg;
        fin_valid_next = fin_valid_reg;
        if (fin_valid_reg && fin_take) begin
            fin_valid_next = 1'b0;
        end
        if (beat.valid) begin
            if (beat.last) begin
                st_next        = ST_CLEAR;
                fin_next       = nx;
                fin_valid_next = 1'b1;
            end else begin
                st_next = nx;
            end
        end
    end

    // Close the string as if a terminator followed the last character.
    always_comb begin
        done_t fd;
        fd         = '0;
        res_value  = fin_reg.acc;
        res_count  = fin_reg.cnt;
        res_status = fin_reg.status;
        case (fin_reg.phase)
            PH_SKIP, PH_SIGN: begin
                res_value  = '0;
                res_count  = '0;
                res_status = AIP_INVALID;
            end
            PH_PREFIX: begin
                fd         = finish_value('0, fin_reg.status, fin_reg.neg, mask,
                                          cfg.signed_mode);
                res_value  = fd.acc;
                res_count  = fin_reg.zpc;
                res_status = fd.status;
            end
            PH_ZAUTO, PH_ZFIX, PH_DIGITS: begin
                fd         = finish_value(fin_reg.acc, fin_reg.status, fin_reg.neg, mask,
                                          cfg.signed_mode);
                res_value  = fd.acc;
                res_status = fd.status;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_CLEAR;
            fin_valid_reg <= 1'b0;
        end else begin
            st_reg        <= st_next;
            fin_valid_reg <= fin_valid_next;
        end
        fin_reg <= fin_next;
    end

    assign fin_valid = fin_valid_reg;
    assign fin_free  = !fin_valid_reg || fin_take;

endmodule

[hw/rtl/aip_checker.sv]
// Port-level checks of the ASCII integer parser and their bind to the top.
// Depends on aip_pkg and ascii_integer_parser_assert.svh.
`include "ascii_integer_parser_assert.svh"

module aip_checker #(
    parameter int unsigned VALUE_BITS = 64,
    parameter int unsigned COUNT_BITS = 16,
    localparam int unsigned M_TDATA_BITS = ((VALUE_BITS + 2 + COUNT_BITS + 7) / 8) * 8
) (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_tready,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [M_TDATA_BITS-1:0] m_tdata
);
    import aip_pkg::*;

    logic [VALUE_BITS-1:0] value_f;
    logic [1:0]            status_f;
    logic [COUNT_BITS-1:0] count_f;
    logic                  held_beat;
    logic                  invalid_beat;

    assign value_f  = m_tdata[VALUE_BITS-1:0];
    assign status_f = m_tdata[VALUE_BITS+1:VALUE_BITS];
    assign count_f  = m_tdata[VALUE_BITS+COUNT_BITS+1:VALUE_BITS+2];

    assign held_beat    = m_tvalid && !m_tready;
    assign invalid_beat = m_tvalid && status_f == AIP_INVALID;

    // Input stalls only when the whole pipe is full behind a held result.
    `AIP_ASSERT_NOW(a_stall_needs_full, aclk, aresetn, !s_tready, held_beat)

    // An invalid string reports no value and no consumed characters.
    `AIP_ASSERT_NOW(a_invalid_zero, aclk, aresetn, invalid_beat, value_f == '0 && count_f == '0)

    `AIP_ASSERT_NEXT(a_hold_result, aclk, aresetn, held_beat, m_tvalid && $stable(m_tdata))

endmodule

bind ascii_integer_parser aip_checker #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
) u_aip_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[sim/ascii_integer_parser_tb.sv]
// Self-checking testbench for ascii_integer_parser: streams strings one character per beat and
// checks each result beat against a predictor of the parse or a typed table value. Depends on
// aip_pkg and the RTL of ascii_integer_parser.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import aip_pkg::*;

    localparam int VALUE_W      = 64;
    localparam int COUNT_W      = 16;
    localparam int M_BITS       = ((VALUE_W + 2 + COUNT_W + 7) / 8) * 8;
    localparam int PIPE_DEPTH   = 3;
    localparam int MAX_GAP      = 8;
    localparam int RANDOM_CHARS = 1800;
    localparam int REPORT_MAX   = 10;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    localparam logic [1:0]  REG_SPARE     = 2'd3;
    localparam logic [5:0]  RADIX_ONE     = 6'd1;
    localparam logic [5:0]  RADIX_OVER    = 6'd37;
    localparam logic [5:0]  RADIX_TOP     = 6'd63;
    localparam logic        MODE_UNSIGNED = 1'b0;
    localparam logic        MODE_SIGNED   = 1'b1;
    localparam logic [7:0]  CH_NUL        = 8'h00;
    localparam logic [63:0] ALL_ONES      = '1;

    typedef enum logic [2:0] {
        SCAN_BLANKS,
        SCAN_AFTER_SIGN,
        SCAN_ZERO_AUTO,
        SCAN_ZERO_FIXED,
        SCAN_PREFIX,
        SCAN_DIGITS,
        SCAN_STOPPED
    } scan_phase_t;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
        logic [15:0] count;
    } number_t;

    typedef struct packed {
        logic [5:0]   radix;
        logic         sgn;
        logic [1:0]   wsel;
        logic [4:0]   len;
        logic [159:0] text;
        logic         chk;
        number_t      want;
    } vector_row_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = REG_RADIX;
    logic [5:0]        cfg_data  = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = '0;
    logic              s_tlast   = 1'b0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [M_BITS-1:0] m_tdata;

    // predictor copy of the registers and the parse state
    logic [5:0]  cfg_radix = RADIX_AUTO;
    logic        cfg_sgn   = MODE_UNSIGNED;
    logic [1:0]  cfg_wsel  = WSEL_64;
    scan_phase_t scan_phase;
    logic [63:0] acc_value;
    logic        neg_sign;
    logic [5:0]  base_used;
    logic [15:0] used_chars;
    logic [15:0] prefix_mark;
    logic [1:0]  scan_status;

    number_t     expected_numbers[$];
    vector_row_t vector_table[$];
    logic [7:0]  char_buf[$];
    number_t     typed_number;
    logic        typed_valid = 1'b0;
    logic        calm        = 1'b0;
    int          sent_chars  = 0;
    int          failures    = 0;
    int          stall_left  = 0;
    int unsigned cycle_count = 0;

    ascii_integer_parser #(
        .VALUE_BITS(VALUE_W),
        .COUNT_BITS(COUNT_W)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void clear_scan();
        scan_phase  = SCAN_BLANKS;
        acc_value   = '0;
        neg_sign    = 1'b0;
        base_used   = '0;
        used_chars  = '0;
        prefix_mark = '0;
        scan_status = AIP_OK;
    endfunction

    function automatic logic [63:0] width_ones();
        case (cfg_wsel)
            WSEL_8:  return 64'hFF;
            WSEL_16: return 64'hFFFF;
            WSEL_32: return 64'hFFFF_FFFF;
            default: return ALL_ONES;
        endcase
    endfunction

    // largest magnitude that fits; also the saturation value on overflow
    function automatic logic [63:0] value_ceiling();
        logic [63:0] m;
        m = width_ones();
        if (cfg_sgn == MODE_UNSIGNED) return m;
        return neg_sign ? (m >> 1) + 64'd1 : (m >> 1);
    endfunction

    function automatic logic [6:0] char_weight(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9) return 7'(c - CH_0);
        if (c >= CH_UA && c <= CH_UZ) return 7'(c - CH_UA) + DIGIT_TEN;
        if (c >= CH_LA && c <= CH_LZ) return 7'(c - CH_LA) + DIGIT_TEN;
        return DIGIT_NONE;
    endfunction

    function automatic logic is_hex_mark(input logic [7:0] c);
        return (c == CH_LX) || (c == CH_UX);
    endfunction

    function automatic logic is_bin_mark(input logic [7:0] c);
        return (c == CH_LB) || (c == CH_UB);
    endfunction

    function automatic void count_char();
        if (used_chars != '1) used_chars = used_chars + 16'd1;
    endfunction

    function automatic void mark_invalid();
        scan_status = AIP_INVALID;
        acc_value   = '0;
        used_chars  = '0;
        scan_phase  = SCAN_STOPPED;
    endfunction

    function automatic void close_number();
        if (scan_status == AIP_RANGE || acc_value > value_ceiling()) begin
            scan_status = AIP_RANGE;
            acc_value   = value_ceiling();
        end else if (neg_sign) begin
            acc_value = (64'd0 - acc_value) & width_ones();
        end else begin
            acc_value = acc_value & width_ones();
        end
        scan_phase = SCAN_STOPPED;
    endfunction

    function automatic void take_digit(input logic [7:0] c);
        logic [63:0] d;
        logic [63:0] b;
        d = 64'(char_weight(c));
        b = (base_used < RADIX_BIN) ? 64'(RADIX_BIN) : 64'(base_used);
        if (d >= b) begin
            close_number();
            return;
        end
        count_char();
        // past an overflow, digits are consumed but the value is frozen
        if (scan_status == AIP_RANGE) return;
        if (acc_value > (value_ceiling() - d) / b) scan_status = AIP_RANGE;
        else acc_value = acc_value * b + d;
    endfunction

    function automatic void begin_digits(input logic [7:0] c);
        acc_value  = '0;
        scan_phase = SCAN_DIGITS;
        take_digit(c);
    endfunction

    function automatic void first_significant(input logic [7:0] c);
        if (cfg_radix == RADIX_AUTO) begin
            if (c == CH_0) begin
                count_char();
                scan_phase = SCAN_ZERO_AUTO;
            end else if (c >= CH_1 && c <= CH_9) begin
                base_used = RADIX_DEC;
                begin_digits(c);
            end else begin
                mark_invalid();
            end
        end else if (cfg_radix < RADIX_BIN || cfg_radix > RADIX_MAX) begin
            mark_invalid();
        end else if ((cfg_radix == RADIX_HEX || cfg_radix == RADIX_BIN) && c == CH_0) begin
            base_used = cfg_radix;
            count_char();
            scan_phase = SCAN_ZERO_FIXED;
        end else if (char_weight(c) < 7'(cfg_radix)) begin
            base_used = cfg_radix;
            begin_digits(c);
        end else begin
            mark_invalid();
        end
    endfunction

    function automatic void predict_char(input logic [7:0] c);
        case (scan_phase)
            SCAN_BLANKS: begin
                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                    count_char();
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                    neg_sign = (c == CH_MINUS);
                    count_char();
                    scan_phase = SCAN_AFTER_SIGN;
                end else begin
                    first_significant(c);
                end
            end
            SCAN_AFTER_SIGN: first_significant(c);
            SCAN_ZERO_AUTO: begin
                if (is_hex_mark(c) || is_bin_mark(c)) begin
                    prefix_mark = used_chars;
                    count_char();
                    base_used  = is_hex_mark(c) ? RADIX_HEX : RADIX_BIN;
                    scan_phase = SCAN_PREFIX;
                end else begin
                    base_used = RADIX_OCT;
                    begin_digits(c);
                end
            end
            SCAN_ZERO_FIXED: begin
                if ((base_used == RADIX_HEX && is_hex_mark(c)) ||
                    (base_used == RADIX_BIN && is_bin_mark(c))) begin
                    prefix_mark = used_chars;
                    count_char();
                    scan_phase = SCAN_PREFIX;
                end else begin
                    begin_digits(c);
                end
            end
            SCAN_PREFIX: begin
                // a prefix with no digit behind it falls back to the bare zero
                if (char_weight(c) < 7'(base_used)) begin
                    begin_digits(c);
                end else begin
                    used_chars = prefix_mark;
                    acc_value  = '0;
                    close_number();
                end
            end
            SCAN_DIGITS: take_digit(c);
            default: ;
        endcase
    endfunction

    function automatic number_t predict_string_end();
        number_t r;
        predict_char(CH_NUL);
        r.value  = (scan_status == AIP_INVALID) ? 64'd0 : acc_value;
        r.status = scan_status;
        r.count  = used_chars;
        clear_scan();
        return r;
    endfunction

    function automatic void apply_config(input logic [1:0] index, input logic [5:0] data);
        case (index)
            REG_RADIX:  cfg_radix = data;
            REG_SIGNED: cfg_sgn   = data[0];
            REG_WIDTH:  cfg_wsel  = data[1:0];
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- drivers

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task automatic send_char(input logic [7:0] c, input logic is_last);
        int      gap;
        number_t got;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
        sent_chars++;
        predict_char(c);
        if (is_last) begin
            got = predict_string_end();
            expected_numbers.push_back(typed_valid ? typed_number : got);
        end
    endtask

    task automatic send_buffer();
        for (int i = 0; i < char_buf.size(); i++) begin
            send_char(char_buf[i], i == char_buf.size() - 1);
        end
    endtask

    // hold the input until every pending number has come out and the pipe is empty
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_numbers.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [5:0] data);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            cfg_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        apply_config(index, data);
    endtask

    task automatic program_regs(input logic [5:0] radix, input logic sgn, input logic [1:0] wsel);
        int order;
        order = $urandom_range(0, 2);
        if ($urandom_range(0, 4) == 0) write_reg(REG_SPARE, 6'($urandom));
        // rotate the order of the three writes; unused data bits get noise
        for (int k = 0; k < 3; k++) begin
            case ((order + k) % 3)
                0:       write_reg(REG_RADIX, radix);
                1:       write_reg(REG_SIGNED, {5'($urandom), sgn});
                default: write_reg(REG_WIDTH, {4'($urandom), wsel});
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------- string builder

    function automatic logic [7:0] digit_char(input int v);
        if (v < 10) return CH_0 + 8'(v);
        return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(v - 10);
    endfunction

    function automatic logic [7:0] blank_char();
        int pick;
        pick = $urandom_range(0, 5);
        return (pick == 5) ? CH_SPACE : CH_TAB + 8'(pick);
    endfunction

    task automatic build_random_string();
        int  base;
        int  ndig;
        int  pick;
        logic first_nonzero;
        char_buf.delete();
        if ($urandom_range(0, 9) < 2) begin
            repeat ($urandom_range(1, 6)) char_buf.push_back(8'($urandom));
            return;
        end
        first_nonzero = 1'b0;
        repeat ($urandom_range(0, 2)) char_buf.push_back(blank_char());
        pick = $urandom_range(0, 3);
        if (pick == 0) char_buf.push_back(CH_PLUS);
        else if (pick == 1) char_buf.push_back(CH_MINUS);
        if (cfg_radix == RADIX_AUTO) begin
            pick = $urandom_range(0, 3);
            if (pick == 0) begin
                base = 10;
                first_nonzero = 1'b1;
            end else begin
                char_buf.push_back(CH_0);
                if (pick == 1) begin
                    base = 16;
                    char_buf.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
                end else if (pick == 2) begin
                    base = 2;
                    char_buf.push_back($urandom_range(0, 1) ? CH_LB : CH_UB);
                end else begin
                    base = 8;
                end
            end
        end else if (cfg_radix >= RADIX_BIN && cfg_radix <= RADIX_MAX) begin
            base = int'(cfg_radix);
            if ($urandom_range(0, 1) == 0) begin
                if (cfg_radix == RADIX_HEX) begin
                    char_buf.push_back(CH_0);
                    char_buf.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
                end else if (cfg_radix == RADIX_BIN) begin
                    char_buf.push_back(CH_0);
                    char_buf.push_back($urandom_range(0, 1) ? CH_LB : CH_UB);
                end
            end
        end else begin
            base = 10;
        end
        if ($urandom_range(0, 9) == 0) ndig = 0;
        else if ($urandom_range(0, 3) == 0) ndig = $urandom_range(1, (base <= 4) ? 70 : 25);
        else ndig = $urandom_range(1, 5);
        for (int i = 0; i < ndig; i++) begin
            char_buf.push_back(digit_char($urandom_range((i == 0 && first_nonzero) ? 1 : 0,
                                                         base - 1)));
        end
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) char_buf.push_back(8'($urandom));
        end
        if (char_buf.size() == 0) char_buf.push_back(8'($urandom));
    endtask

    task automatic add_row(input logic [5:0] radix, input logic sgn, input logic [1:0] wsel,
                           input int len, input logic [159:0] text, input logic chk,
                           input logic [63:0] value, input logic [1:0] status,
                           input logic [15:0] count);
        vector_row_t row;
        row.radix = radix;
        row.sgn   = sgn;
        row.wsel  = wsel;
        row.len   = 5'(len);
        row.text  = text;
        row.chk   = chk;
        row.want  = '{value: value, status: status, count: count};
        vector_table.push_back(row);
    endtask

    // ---------------------------------------------------------------- result side

    always @(posedge aclk) begin : result_side
        number_t want;
        logic    next_ready;
        next_ready = m_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_numbers.size() == 0) begin
                    failures++;
                    if (failures <= REPORT_MAX) begin
                        $display("unexpected result beat: value %h status %0d count %0d",
                                 m_tdata[63:0], m_tdata[65:64], m_tdata[81:66]);
                    end
                end else begin
                    want = expected_numbers.pop_front();
                    if (m_tdata[63:0] !== want.value || m_tdata[65:64] !== want.status ||
                        m_tdata[81:66] !== want.count) begin
                        failures++;
                        if (failures <= REPORT_MAX) begin
                            $display("mismatch: value exp %h got %h",
                                     want.value, m_tdata[63:0]);
                            $display("  status exp %0d got %0d, count exp %0d got %0d",
                                     want.status, m_tdata[65:64],
                                     want.count, m_tdata[81:66]);
                        end
                    end
                end
                stall_left = calm ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall_left > 0) begin
                stall_left--;
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
            end
        end
        m_tready <= next_ready;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    initial begin : stimulus
        vector_row_t row;
        int          start_chars;
        logic [5:0]  radix;
        logic        sgn;
        logic [1:0]  wsel;
        int          pick;

        clear_scan();

        // after reset: auto radix, unsigned, 64 bits
        add_row(RADIX_AUTO, MODE_UNSIGNED, WSEL_64, 1, "0", 1'b1, 64'd0, AIP_OK, 16'd1);
        add_row(RADIX_AUTO, MODE_UNSIGNED, WSEL_64, 20, "18446744073709551615", 1'b1,
                ALL_ONES, AIP_OK, 16'd20);
        add_row(RADIX_AUTO, MODE_UNSIGNED, WSEL_64, 20, "18446744073709551616", 1'b1,
                ALL_ONES, AIP_RANGE, 16'd20);
        add_row(RADIX_AUTO, MODE_UNSIGNED, WSEL_64, 2, "-1", 1'b1, ALL_ONES, AIP_OK, 16'd2);
        add_row(RADIX_AUTO, MODE_UNSIGNED, WSEL_64, 3, "xyz", 1'b1, 64'd0, AIP_INVALID, 16'd0);
        add_row(RADIX_AUTO, MODE_UNSIGNED, WSEL_64, 9,
                {CH_SPACE, CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR, "+42"}, 1'b1,
                64'd42, AIP_OK, 16'd9);
        add_row(RADIX_AUTO, MODE_UNSIGNED, WSEL_64, 2, "0x", 1'b1, 64'd0, AIP_OK, 16'd1);
        add_row(RADIX_AUTO, MODE_UNSIGNED, WSEL_64, 3, "0xG", 1'b1, 64'd0, AIP_OK, 16'd1);
        add_row(RADIX_AUTO, MODE_UNSIGNED, WSEL_64, 5, "0b101", 1'b1, 64'd5, AIP_OK, 16'd5);
        add_row(RADIX_AUTO, MODE_UNSIGNED, WSEL_64, 5, "0X7fZ", 1'b1, 64'h7F, AIP_OK, 16'd4);
        add_row(RADIX_AUTO, MODE_UNSIGNED, WSEL_64, 3, "089", 1'b1, 64'd0, AIP_OK, 16'd1);
        add_row(RADIX_AUTO, MODE_UNSIGNED, WSEL_64, 4, "0777", 1'b1, 64'd511, AIP_OK, 16'd4);
        add_row(RADIX_AUTO, MODE_UNSIGNED, WSEL_64, 5, {"12", CH_NUL, "34"}, 1'b1,
                64'd12, AIP_OK, 16'd2);
        add_row(RADIX_AUTO, MODE_UNSIGNED, WSEL_64, 2, {"7", 8'hFF}, 1'b1, 64'd7, AIP_OK, 16'd1);
        add_row(RADIX_AUTO, MODE_UNSIGNED, WSEL_64, 2, {CH_SPACE, CH_TAB}, 1'b1,
                64'd0, AIP_INVALID, 16'd0);
        // widest radix, signed, 8 bits: both saturation edges; then radices out of range
        add_row(RADIX_MAX, MODE_SIGNED, WSEL_8, 2, "zz", 1'b1, 64'h7F, AIP_RANGE, 16'd2);
        add_row(RADIX_MAX, MODE_SIGNED, WSEL_8, 3, "-3k", 1'b1, 64'h80, AIP_OK, 16'd3);
        add_row(RADIX_MAX, MODE_SIGNED, WSEL_8, 3, "-3l", 1'b1, 64'h80, AIP_RANGE, 16'd3);
        add_row(RADIX_ONE, MODE_SIGNED, WSEL_8, 1, "5", 1'b1, 64'd0, AIP_INVALID, 16'd0);
        add_row(RADIX_TOP, MODE_SIGNED, WSEL_8, 1, "5", 1'b1, 64'd0, AIP_INVALID, 16'd0);
        add_row(RADIX_HEX, MODE_UNSIGNED, WSEL_16, 6, "0xFFFF", 1'b1, 64'hFFFF, AIP_OK, 16'd6);
        add_row(RADIX_HEX, MODE_UNSIGNED, WSEL_16, 4, "-0x1", 1'b1, 64'hFFFF, AIP_OK, 16'd4);
        add_row(RADIX_HEX, MODE_UNSIGNED, WSEL_16, 7, "0x10000", 1'b1,
                64'hFFFF, AIP_RANGE, 16'd7);
        add_row(RADIX_BIN, MODE_SIGNED, WSEL_32, 2, "0b", 1'b1, 64'd0, AIP_OK, 16'd1);
        add_row(RADIX_BIN, MODE_SIGNED, WSEL_32, 7, "-0B1111", 1'b0, 64'd0, AIP_OK, 16'd0);
        add_row(RADIX_DEC, MODE_SIGNED, WSEL_64, 20, "-9223372036854775808", 1'b1,
                64'h8000_0000_0000_0000, AIP_OK, 16'd20);
        add_row(RADIX_DEC, MODE_SIGNED, WSEL_64, 19, "9223372036854775808", 1'b1,
                64'h7FFF_FFFF_FFFF_FFFF, AIP_RANGE, 16'd19);
        add_row(RADIX_OCT, MODE_UNSIGNED, WSEL_32, 4, "0x12", 1'b1, 64'd0, AIP_OK, 16'd1);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < vector_table.size(); r++) begin
            row = vector_table[r];
            if (row.radix != cfg_radix || row.sgn != cfg_sgn || row.wsel != cfg_wsel) begin
                wait_drained();
                program_regs(row.radix, row.sgn, row.wsel);
            end
            char_buf.delete();
            for (int i = 0; i < int'(row.len); i++) begin
                char_buf.push_back(row.text[8 * (int'(row.len) - 1 - i) +: 8]);
            end
            typed_valid  = row.chk;
            typed_number = row.want;
            send_buffer();
        end
        typed_valid = 1'b0;

        start_chars = sent_chars;
        while (sent_chars < start_chars + RANDOM_CHARS) begin
            pick = $urandom_range(0, 9);
            case (pick)
                2:       radix = RADIX_BIN;
                3:       radix = RADIX_OCT;
                4:       radix = RADIX_DEC;
                5:       radix = RADIX_HEX;
                6:       radix = RADIX_MAX;
                7:       radix = 6'($urandom_range(RADIX_BIN, RADIX_MAX));
                8:       radix = $urandom_range(0, 1) ? RADIX_ONE
                                 : 6'($urandom_range(RADIX_OVER, RADIX_TOP));
                default: radix = RADIX_AUTO;
            endcase
            sgn  = $urandom_range(0, 1) ? MODE_SIGNED : MODE_UNSIGNED;
            wsel = 2'($urandom_range(0, 3));
            calm = 1'b0;
            wait_drained();
            program_regs(radix, sgn, wsel);
            calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(10, 40)) begin
                build_random_string();
                send_buffer();
            end
        end

        calm = 1'b0;
        wait_drained();
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/aip_pkg.sv
hw/rtl/aip_parse_core.sv
hw/rtl/ascii_integer_parser.sv
hw/rtl/aip_checker.sv
sim/ascii_integer_parser_tb.sv
